@@ hw/rtl/rgb_status_led_controller_defines.svh @@
// ---------------------------------------------------------------------------
// rgb status led controller assertion macros
// shared property forms used by the controller checks
// ---------------------------------------------------------------------------
`ifndef RGB_STATUS_LED_CONTROLLER_DEFINES_SVH
`define RGB_STATUS_LED_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RGBSL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbsl check failed");

// next-cycle implication, disabled during reset
`define RGBSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbsl check failed");

`endif

@@ hw/rtl/rgbsl_pkg.sv @@
// ---------------------------------------------------------------------------
// rgbsl_pkg
// types, codes and the status color table of the rgb status led controller
// ---------------------------------------------------------------------------
`default_nettype none

package rgbsl_pkg;

  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned STEP_W   = 9;   // floor(65535 / 255) = 257
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 48;

  // x / 255 == (x * 32897) >> 23 for every 16-bit x
  localparam logic [16:0] STEP_RECIP = 17'd32897;
  localparam int unsigned STEP_SHIFT = 23;
  localparam logic [STEP_W-1:0] STEP_RESET = 9'd257;
  localparam logic [CFG_W-1:0]  HOLD_RESET = 16'd300;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_COLOR  = 2'd1,
    CMD_STATUS     = 2'd2,
    CMD_RESERVED   = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_PWM_PERIOD = 1'b0,
    CFG_HOLD_MS    = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_SUCCESS      = 3'd0,
    ST_LOCKED       = 3'd1,
    ST_SHUTDOWN     = 3'd2,
    ST_NOT_CHARGING = 3'd3,
    ST_CC_CHARGING  = 3'd4,
    ST_CV_CHARGING  = 3'd5,
    ST_DONE         = 3'd6,
    ST_UNUSED       = 3'd7
  } status_t;

  typedef struct packed {
    logic                valid;
    logic [LEVEL_W-1:0]  red;
    logic [LEVEL_W-1:0]  green;
    logic [LEVEL_W-1:0]  blue;
    logic                transient;
  } status_color_t;

  function automatic status_color_t status_lookup(input logic [2:0] code);
    status_color_t c;
    c = '{valid: 1'b1, red: 8'd0, green: 8'd0, blue: 8'd0, transient: 1'b1};
    unique case (status_t'(code))
      ST_SUCCESS:      begin c.red = 8'd10; c.green = 8'd10; c.blue = 8'd10; end
      ST_LOCKED:       begin c.blue = 8'd20; c.transient = 1'b0; end
      ST_SHUTDOWN:     begin c.red = 8'd20; c.green = 8'd20; c.blue = 8'd20; end
      ST_NOT_CHARGING: begin c.red = 8'd10; c.blue = 8'd10; end
      ST_CC_CHARGING:  begin c.red = 8'd2; end
      ST_CV_CHARGING:  begin c.red = 8'd2; c.green = 8'd2; end
      ST_DONE:         begin c.green = 8'd2; end
      default:         begin c.valid = 1'b0; c.transient = 1'b0; end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rgb_status_led_controller.sv @@
// ---------------------------------------------------------------------------
// rgb_status_led_controller
// chooses the led color per event word and scales it to three pwm duties
// ---------------------------------------------------------------------------
// usage
//   s_axis: one event word per handshake; tuser carries the command
//   (tick, set user color, show status), tdata the time and color fields
//   m_axis: one pwm write word (red, green, blue duty) per event that
//   changes the shown color; ticks inside the hold time and color sets
//   during a transient status give no word
//   cfg: write pwm_period (index 0) or hold_ms (index 1) while idle; the
//   duty step floor(period / 255) is computed and registered at the write
//   path: a result word passes the level stage, then the output register
//   throughput: one event per cycle unless stalled; the color decision and
//   state update finish in the accept cycle, three 8x9 duty multiplies the next
//   stall: while m_axis_tready is low the output word holds, the level
//   stage keeps one more word and s_axis_tready drops only once both full
//   reset: user color black, no transient status, times zero, period
//   65535 (step 257), hold 300 ms; no word pending
// ---------------------------------------------------------------------------
`default_nettype none

`include "rgb_status_led_controller_defines.svh"

module rgb_status_led_controller (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // config write port
  input  wire logic                                cfg_we,
  input  wire logic [0:0]                          cfg_index,
  input  wire logic [rgbsl_pkg::CFG_W-1:0]         cfg_data,
  // event words
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // time_ms[31:0], red[39:32], green[47:40], blue[55:48], status_code[58:56]
  input  wire logic [rgbsl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]                          s_axis_tuser,
  // pwm write words
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // duty_red[15:0], duty_green[31:16], duty_blue[47:32]
  output      logic [rgbsl_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import rgbsl_pkg::*;

  // configuration
  logic [STEP_W-1:0]  duty_step;
  logic [CFG_W-1:0]   hold_ms;
  logic [32:0]        step_prod;

  // controller state
  logic [TIME_W-1:0]  now_ms;
  logic [TIME_W-1:0]  change_ms;
  logic               transient_active;
  logic [LEVEL_W-1:0] user_red, user_green, user_blue;

  // level stage
  logic               lvl_valid;
  logic [LEVEL_W-1:0] lvl_red, lvl_green, lvl_blue;

  // input fields
  cmd_t               in_cmd;
  logic [TIME_W-1:0]  in_time;
  logic [LEVEL_W-1:0] in_red, in_green, in_blue;
  logic [2:0]         in_code;

  logic               accept;
  logic               out_en;
  logic [TIME_W-1:0]  elapsed;
  status_color_t      st_color;

  // decision of the accepted event
  logic               fire;
  logic [LEVEL_W-1:0] sel_red, sel_green, sel_blue;
  logic               transient_next;
  logic               now_update;
  logic               user_update;

  logic [STEP_W+LEVEL_W-1:0] prod_red, prod_green, prod_blue;

  assign in_cmd   = cmd_t'(s_axis_tuser);
  assign in_time  = s_axis_tdata[31:0];
  assign in_red   = s_axis_tdata[39:32];
  assign in_green = s_axis_tdata[47:40];
  assign in_blue  = s_axis_tdata[55:48];
  assign in_code  = s_axis_tdata[58:56];

  // output register moves when empty or drained; level stage may fill
  // while the output word waits
  assign out_en        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !lvl_valid || out_en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign elapsed  = in_time - change_ms;   // 32-bit wrap
  assign st_color = status_lookup(in_code);

  // period / 255 by reciprocal multiply, exact over 16 bits
  assign step_prod = {1'b0, cfg_data} * {16'd0, STEP_RECIP};

  always_comb begin
    fire           = 1'b0;
    sel_red        = user_red;
    sel_green      = user_green;
    sel_blue       = user_blue;
    transient_next = transient_active;
    now_update     = 1'b0;
    user_update    = 1'b0;
    unique case (in_cmd)
      CMD_TICK: begin
        now_update = 1'b1;
        if (transient_active && (elapsed > {16'd0, hold_ms})) begin
          fire           = 1'b1;
          transient_next = 1'b0;
        end
      end
      CMD_SET_COLOR: begin
        user_update = 1'b1;
        sel_red     = in_red;
        sel_green   = in_green;
        sel_blue    = in_blue;
        fire        = !transient_active;
      end
      CMD_STATUS: begin
        // unused status code is dropped with no state change
        if (st_color.valid) begin
          fire           = 1'b1;
          sel_red        = st_color.red;
          sel_green      = st_color.green;
          sel_blue       = st_color.blue;
          transient_next = st_color.transient;
        end
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_step        <= STEP_RESET;
      hold_ms          <= HOLD_RESET;
      now_ms           <= '0;
      change_ms        <= '0;
      transient_active <= 1'b0;
      user_red         <= '0;
      user_green       <= '0;
      user_blue        <= '0;
      lvl_valid        <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_PWM_PERIOD: duty_step <= step_prod[STEP_SHIFT +: STEP_W];
          CFG_HOLD_MS:    hold_ms   <= cfg_data;
          default:        hold_ms   <= hold_ms;
        endcase
      end

      if (accept) begin
        if (now_update) begin
          now_ms <= in_time;
        end
        if (user_update) begin
          user_red   <= in_red;
          user_green <= in_green;
          user_blue  <= in_blue;
        end
        if (fire) begin
          transient_active <= transient_next;
          // a tick writes its own time; other events use the last tick
          change_ms        <= now_update ? in_time : now_ms;
        end
      end

      if (s_axis_tready) begin
        lvl_valid <= accept && fire;
      end
      if (out_en) begin
        m_axis_tvalid <= lvl_valid;
      end
    end
  end

  // level payload, no reset
  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      lvl_red   <= sel_red;
      lvl_green <= sel_green;
      lvl_blue  <= sel_blue;
    end
  end

  assign prod_red   = {{STEP_W{1'b0}}, lvl_red}   * {{LEVEL_W{1'b0}}, duty_step};
  assign prod_green = {{STEP_W{1'b0}}, lvl_green} * {{LEVEL_W{1'b0}}, duty_step};
  assign prod_blue  = {{STEP_W{1'b0}}, lvl_blue}  * {{LEVEL_W{1'b0}}, duty_step};

  // duty wraps to 16 bits
  always_ff @(posedge clk) begin
    if (out_en) begin
      m_axis_tdata <= {prod_blue[DUTY_W-1:0], prod_green[DUTY_W-1:0],
                       prod_red[DUTY_W-1:0]};
    end
  end

  // checks
  `RGBSL_ASSERT_NEXT(a_idle_tick_silent, clk, rst,
    accept && (in_cmd == CMD_TICK) && !transient_active, !lvl_valid)
  `RGBSL_ASSERT_NEXT(a_set_during_transient_silent, clk, rst,
    accept && (in_cmd == CMD_SET_COLOR) && transient_active, !lvl_valid)
  `RGBSL_ASSERT_NEXT(a_locked_not_transient, clk, rst,
    accept && (in_cmd == CMD_STATUS) && (status_t'(in_code) == ST_LOCKED),
    !transient_active)
  `RGBSL_ASSERT_NEXT(a_level_reaches_output, clk, rst,
    lvl_valid && out_en, m_axis_tvalid)

endmodule

`default_nettype wire
